### hdl/afr_pkg.sv
package afr_pkg;

  // Command table size (up to 4 entries take part in matching; a zero code never matches)
  localparam int NUM_COMMANDS = 4;
  localparam int CODE_W       = 24;
  localparam int CFG_IDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd4;

  // Parse phases
  localparam logic [3:0] PH_TYPE   = 4'd0;
  localparam logic [3:0] PH_CMD    = 4'd1;
  localparam logic [3:0] PH_COLON1 = 4'd2;
  localparam logic [3:0] PH_LEN    = 4'd3;
  localparam logic [3:0] PH_COLON2 = 4'd4;
  localparam logic [3:0] PH_DBIN   = 4'd5;
  localparam logic [3:0] PH_DASC   = 4'd6;
  localparam logic [3:0] PH_DESC   = 4'd7;
  localparam logic [3:0] PH_COLON3 = 4'd8;
  localparam logic [3:0] PH_CSUM   = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;
  localparam logic [3:0] PH_ERROR  = 4'd11;

  // Event kinds
  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_OK   = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  // Message types
  localparam logic [2:0] MT_NONE     = 3'd0;
  localparam logic [2:0] MT_REQUEST  = 3'd1;
  localparam logic [2:0] MT_RESPONSE = 3'd2;
  localparam logic [2:0] MT_ERROR    = 3'd3;
  localparam logic [2:0] MT_UPDATE   = 3'd4;

  localparam logic [2:0] CMD_NO_MATCH = 3'd4;

  // Characters
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_REQUEST   = 8'h3E;  // '>'
  localparam logic [7:0] CH_RESPONSE  = 8'h3C;  // '<'
  localparam logic [7:0] CH_ERROR     = 8'h21;  // '!'
  localparam logic [7:0] CH_UPDATE    = 8'h23;  // '#'
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] MAX_LEN_RST  = 8'hFF;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] message_type;
    logic [2:0] command_index;
    logic [7:0] data_value;
    logic [7:0] data_offset;
    logic       last_data;
  } event_t;

  // Bit 4: character is a hex digit; bits 3:0: its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### hdl/afr_channels.sv
interface afr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface afr_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [2:0] message_type;
  logic [2:0] command_index;
  logic [7:0] data_value;
  logic [7:0] data_offset;
  logic       last_data;
  modport source (output valid, output event_kind, output message_type,
                  output command_index, output data_value, output data_offset,
                  output last_data, input ready);
  modport sink (input valid, input event_kind, input message_type,
                input command_index, input data_value, input data_offset,
                input last_data, output ready);
endinterface

interface afr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [afr_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [afr_pkg::CODE_W-1:0]      wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

### hdl/ascii_frame_receiver.sv
// Channel   Dir  Payload                                             Handshake
// in_chan   in   rx_char                                             valid/ready
// out_chan  out  event_kind message_type command_index data_value
//                data_offset last_data                               valid/ready
// cfg_chan  in   reg_index wr_data                                   valid/ready
//
// One character per cycle while the output buffer has a free slot: each request is parsed in the cycle it is accepted,
// its result (if any) lands in a two-entry output buffer the next cycle.
// in_chan.ready drops only while both buffer entries hold results; cfg_chan is
// always ready. Synchronous active-low reset returns the parser to the type
// mark phase, clears the command codes and sets the maximum length to 255.
module ascii_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  afr_cfg_if.sink     cfg_chan,
  afr_char_if.sink    in_chan,
  afr_event_if.source out_chan
);

  afr_pkg::code_t  codes_r [afr_pkg::NUM_COMMANDS];
  logic [7:0]      max_len_r;

  logic            step;
  logic            buf_full;
  logic            res_valid;
  afr_pkg::event_t res;

  // Configuration writes land directly; indexes past the list are dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afr_pkg::NUM_COMMANDS; i++) begin
        codes_r[i] <= '0;
      end
      max_len_r <= afr_pkg::MAX_LEN_RST;
    end else if (cfg_chan.valid) begin
      for (int i = 0; i < afr_pkg::NUM_COMMANDS; i++) begin
        if (cfg_chan.reg_index == afr_pkg::REG_CODE_0 + afr_pkg::CFG_IDX_W'(i)) begin
          codes_r[i] <= cfg_chan.wr_data;
        end
      end
      if (cfg_chan.reg_index == afr_pkg::REG_MAX_LEN) begin
        max_len_r <= cfg_chan.wr_data[7:0];
      end
    end
  end

  // Accept a character whenever the output buffer has a free slot.
  assign in_chan.ready = !buf_full;
  assign step          = in_chan.valid && in_chan.ready;

  afr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_char   (in_chan.rx_char),
    .codes     (codes_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold results here so the parser keeps running while the sink stalls.
  afr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_chan  (out_chan)
  );

endmodule

### hdl/afr_parser.sv
module afr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_char,
  input  afr_pkg::code_t      codes [afr_pkg::NUM_COMMANDS],
  input  logic [7:0]          max_len,
  output logic                res_valid,
  output afr_pkg::event_t     res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  held_type_r, held_type_nxt;
  logic [2:0]  held_cmd_r, held_cmd_nxt;
  logic [1:0]  char_count_r, char_count_nxt;
  logic [23:0] cmd_chars_r, cmd_chars_nxt;
  logic [3:0]  high_nib_r, high_nib_nxt;
  logic [7:0]  ann_len_r, ann_len_nxt;
  logic [7:0]  bytes_r, bytes_nxt;

  logic [4:0]  hexd;
  logic        pair_done;
  logic [7:0]  hex_byte;
  logic [8:0]  off_inc;
  logic        more_data;
  logic        fail_emits;
  logic [23:0] cmd_cand;

  always_comb begin
    hexd       = afr_pkg::hex_decode(rx_char);
    pair_done  = (char_count_r == 2'd1);
    hex_byte   = {high_nib_r, hexd[3:0]};
    off_inc    = {1'b0, bytes_r} + 9'd1;
    more_data  = (bytes_r < ann_len_r);
    fail_emits = (phase_r >= afr_pkg::PH_COLON2) && (phase_r <= afr_pkg::PH_DONE);
    cmd_cand   = {cmd_chars_r[15:0], rx_char};

    phase_nxt      = phase_r;
    held_type_nxt  = held_type_r;
    held_cmd_nxt   = held_cmd_r;
    char_count_nxt = char_count_r;
    cmd_chars_nxt  = cmd_chars_r;
    high_nib_nxt   = high_nib_r;
    ann_len_nxt    = ann_len_r;
    bytes_nxt      = bytes_r;

    res_valid         = 1'b0;
    res.event_kind    = afr_pkg::EV_FAIL;
    res.message_type  = held_type_r;
    res.command_index = held_cmd_r;
    res.data_value    = 8'd0;
    res.data_offset   = 8'd0;
    res.last_data     = 1'b0;

    if (rx_char == afr_pkg::CH_LF || rx_char == afr_pkg::CH_CR) begin
      res_valid      = 1'b1;
      res.event_kind = (phase_r == afr_pkg::PH_DONE) ? afr_pkg::EV_OK : afr_pkg::EV_FAIL;
      phase_nxt      = afr_pkg::PH_TYPE;
      char_count_nxt = 2'd0;
    end else begin
      unique case (phase_r) inside
        afr_pkg::PH_TYPE: begin
          unique case (rx_char)
            afr_pkg::CH_REQUEST:  held_type_nxt = afr_pkg::MT_REQUEST;
            afr_pkg::CH_RESPONSE: held_type_nxt = afr_pkg::MT_RESPONSE;
            afr_pkg::CH_ERROR:    held_type_nxt = afr_pkg::MT_ERROR;
            afr_pkg::CH_UPDATE:   held_type_nxt = afr_pkg::MT_UPDATE;
            default:              held_type_nxt = afr_pkg::MT_NONE;
          endcase
          phase_nxt = (held_type_nxt != afr_pkg::MT_NONE) ? afr_pkg::PH_CMD
                                                          : afr_pkg::PH_ERROR;
        end
        afr_pkg::PH_COLON1, afr_pkg::PH_COLON2, afr_pkg::PH_COLON3: begin
          if (rx_char == afr_pkg::CH_COLON) begin
            phase_nxt = phase_r + 4'd1;
          end else begin
            res_valid = fail_emits;
            phase_nxt = afr_pkg::PH_ERROR;
          end
        end
        afr_pkg::PH_CMD: begin
          cmd_chars_nxt  = cmd_cand;
          char_count_nxt = char_count_r + 2'd1;
          if (char_count_nxt == 2'd3) begin
            // lowest matching index wins; a zero code never matches
            held_cmd_nxt = afr_pkg::CMD_NO_MATCH;
            for (int i = afr_pkg::NUM_COMMANDS - 1; i >= 0; i--) begin
              if (codes[i] != '0 && codes[i] == cmd_cand) begin
                held_cmd_nxt = 3'(i);
              end
            end
            phase_nxt = (held_cmd_nxt != afr_pkg::CMD_NO_MATCH) ? afr_pkg::PH_COLON1
                                                                : afr_pkg::PH_ERROR;
          end
        end
        afr_pkg::PH_LEN: begin
          if (!hexd[4]) begin
            phase_nxt = afr_pkg::PH_ERROR;
          end else if (pair_done) begin
            char_count_nxt = 2'd2;
            ann_len_nxt    = hex_byte;
            bytes_nxt      = 8'd0;
            phase_nxt      = (hex_byte <= max_len) ? afr_pkg::PH_COLON2
                                                   : afr_pkg::PH_ERROR;
          end else begin
            char_count_nxt = 2'd1;
            high_nib_nxt   = hexd[3:0];
          end
        end
        afr_pkg::PH_DBIN: begin
          if (rx_char == afr_pkg::CH_QUOTE) begin
            phase_nxt = afr_pkg::PH_DASC;
          end else if (more_data) begin
            if (!hexd[4]) begin
              res_valid = 1'b1;
              phase_nxt = afr_pkg::PH_ERROR;
            end else if (pair_done) begin
              char_count_nxt    = 2'd2;
              res_valid         = 1'b1;
              res.event_kind    = afr_pkg::EV_DATA;
              res.data_value    = hex_byte;
              res.data_offset   = bytes_r;
              res.last_data     = (off_inc >= {1'b0, ann_len_r});
              bytes_nxt         = off_inc[7:0];
              if (bytes_nxt >= ann_len_r) begin
                phase_nxt = afr_pkg::PH_COLON3;
              end
            end else begin
              char_count_nxt = 2'd1;
              high_nib_nxt   = hexd[3:0];
            end
          end else if (rx_char == afr_pkg::CH_COLON) begin
            phase_nxt = afr_pkg::PH_CSUM;
          end else begin
            res_valid = 1'b1;
            phase_nxt = afr_pkg::PH_ERROR;
          end
        end
        afr_pkg::PH_DASC: begin
          if (rx_char == afr_pkg::CH_QUOTE) begin
            phase_nxt = more_data ? afr_pkg::PH_DBIN : afr_pkg::PH_COLON3;
          end else if (more_data) begin
            if (rx_char == afr_pkg::CH_BACKSLASH) begin
              phase_nxt = afr_pkg::PH_DESC;
            end else begin
              res_valid       = 1'b1;
              res.event_kind  = afr_pkg::EV_DATA;
              res.data_value  = rx_char;
              res.data_offset = bytes_r;
              res.last_data   = (off_inc >= {1'b0, ann_len_r});
              bytes_nxt       = off_inc[7:0];
            end
          end else begin
            res_valid = 1'b1;
            phase_nxt = afr_pkg::PH_ERROR;
          end
        end
        afr_pkg::PH_DESC: begin
          res_valid       = 1'b1;
          res.event_kind  = afr_pkg::EV_DATA;
          res.data_value  = rx_char;
          res.data_offset = bytes_r;
          res.last_data   = (off_inc >= {1'b0, ann_len_r});
          bytes_nxt       = off_inc[7:0];
          phase_nxt       = (bytes_nxt >= ann_len_r) ? afr_pkg::PH_COLON3
                                                     : afr_pkg::PH_DASC;
        end
        afr_pkg::PH_CSUM: begin
          if (!hexd[4]) begin
            res_valid = 1'b1;
            phase_nxt = afr_pkg::PH_ERROR;
          end else if (pair_done) begin
            char_count_nxt = 2'd2;
            phase_nxt      = afr_pkg::PH_DONE;
          end else begin
            char_count_nxt = 2'd1;
            high_nib_nxt   = hexd[3:0];
          end
        end
        default: begin
          // done and error: drop everything up to the line end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= afr_pkg::PH_TYPE;
      held_type_r  <= afr_pkg::MT_NONE;
      held_cmd_r   <= 3'd0;
      char_count_r <= 2'd0;
      ann_len_r    <= 8'd0;
      bytes_r      <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      held_type_r  <= held_type_nxt;
      held_cmd_r   <= held_cmd_nxt;
      char_count_r <= char_count_nxt;
      ann_len_r    <= ann_len_nxt;
      bytes_r      <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cmd_chars_r <= cmd_chars_nxt;
      high_nib_r  <= high_nib_nxt;
    end
  end

endmodule

### hdl/afr_out_buf.sv
module afr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  afr_pkg::event_t     push_data,
  output logic                full,
  afr_event_if.source         out_chan
);

  afr_pkg::event_t head_r, skid_r;
  logic            head_vld_r, skid_vld_r;
  logic            pop;

  assign pop  = head_vld_r && out_chan.ready;
  assign full = skid_vld_r;

  assign out_chan.valid         = head_vld_r;
  assign out_chan.event_kind    = head_r.event_kind;
  assign out_chan.message_type  = head_r.message_type;
  assign out_chan.command_index = head_r.command_index;
  assign out_chan.data_value    = head_r.data_value;
  assign out_chan.data_offset   = head_r.data_offset;
  assign out_chan.last_data     = head_r.last_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        head_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end else if (push) begin
        head_r <= push_data;
      end else begin
        head_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (head_vld_r) begin
        skid_r     <= push_data;
        skid_vld_r <= 1'b1;
      end else begin
        head_r     <= push_data;
        head_vld_r <= 1'b1;
      end
    end
  end

endmodule
